### rtl/vfh_pkg.sv
// Package of the free sector finder: sizes, register codes, result kinds and shared types.
package vfh_pkg;

   localparam int MAX_BEAMS = 1024;
   localparam int IDX_W     = $clog2(MAX_BEAMS);
   localparam int CNT_W     = $clog2(MAX_BEAMS + 1);
   localparam int MINB_W    = 11;
   localparam int CMP_W     = (CNT_W > MINB_W) ? CNT_W : MINB_W;

   localparam logic [15:0] CLAMP_HIGH = 16'd4000;
   localparam logic [15:0] CLAMP_LOW  = 16'd20;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_VFH_A             = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VFH_B_Q8          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BODY_WIDTH        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FREE_BEAMS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DENSITY_THRESHOLD = 3'd4;

   localparam logic [15:0] RST_VFH_A             = 16'd2000;
   localparam logic [15:0] RST_VFH_B_Q8          = 16'd256;
   localparam logic [12:0] RST_BODY_WIDTH        = 13'd400;
   localparam logic [10:0] RST_MIN_FREE_BEAMS    = 11'd8;
   localparam logic [12:0] RST_DENSITY_THRESHOLD = 13'd1000;

   localparam logic KIND_SECTOR  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [15:0] vfh_a;
      logic [15:0] vfh_b_q8;
      logic [12:0] body_width;
      logic [10:0] min_free_beams;
      logic [12:0] density_threshold;
   } cfg_type;

   typedef struct packed {
      logic is_free;
      logic is_near;
      logic is_negative;
   } beam_type;

   typedef struct packed {
      logic        kind;
      logic [9:0]  sector_start;
      logic [9:0]  sector_end;
      logic [10:0] sector_width;
      logic [10:0] direction_sum;
      logic        collision;
      logic [10:0] near_count;
      logic [10:0] beam_total;
      logic        last;
   } result_type;

   typedef struct packed {
      logic       sector_valid;
      result_type sector;
      logic       summary_valid;
      result_type summary;
   } pair_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v < CNT_W'(MAX_BEAMS)) ? CNT_W'(v + 1'b1) : CNT_W'(MAX_BEAMS);
   endfunction

endpackage

### rtl/vfh_if.sv
// Handshake interfaces of the beam input channel and the result channel.
interface vfh_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] distance;
   logic        last_beam;

   modport source (output valid, output distance, output last_beam, input ready);
   modport sink   (input valid, input distance, input last_beam, output ready);
endinterface

interface vfh_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [9:0]  sector_start;
   logic [9:0]  sector_end;
   logic [10:0] sector_width;
   logic [10:0] direction_sum;
   logic        collision;
   logic [10:0] near_count;
   logic [10:0] beam_total;
   logic        last;

   modport source (output valid, output kind, output sector_start, output sector_end,
                   output sector_width, output direction_sum, output collision,
                   output near_count, output beam_total, output last, input ready);
   modport sink   (input valid, input kind, input sector_start, input sector_end,
                   input sector_width, input direction_sum, input collision,
                   input near_count, input beam_total, input last, output ready);
endinterface

### rtl/vfh_beam_eval.sv
// Per-beam classification: range clamp, body adjustment, free, near and collision tests.
module vfh_beam_eval (
   input  logic [15:0]      distance,
   input  vfh_pkg::cfg_type cfg,
   output vfh_pkg::beam_type beam
);

   logic [11:0]        range_mm;
   logic signed [13:0] adj;
   logic signed [30:0] product;
   logic signed [30:0] limit;

   always_comb begin
      if (distance > vfh_pkg::CLAMP_HIGH || distance < vfh_pkg::CLAMP_LOW) begin
         range_mm = vfh_pkg::CLAMP_HIGH[11:0];
      end else begin
         range_mm = distance[11:0];
      end
   end

   assign adj     = $signed({2'b00, range_mm}) - $signed({2'b00, cfg.body_width[12:1]});
   assign product = $signed({1'b0, cfg.vfh_b_q8}) * adj;
   assign limit   = $signed({7'b0, cfg.vfh_a, 8'b0});

   assign beam.is_free     = (product >= limit);
   assign beam.is_near     = (adj < $signed({1'b0, cfg.density_threshold}));
   assign beam.is_negative = adj[13];

endmodule

### rtl/vfh_scan_track.sv
// Scan state: beam index, free-run bookkeeping, near and collision totals; forms the results.
module vfh_scan_track (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  vfh_pkg::beam_type beam,
   input  logic              last_beam,
   input  logic [10:0]       min_free_beams,
   output vfh_pkg::pair_type pair
);

   logic [vfh_pkg::CNT_W-1:0] beam_index_ff, beam_index_in;
   logic                      in_run_ff, in_run_in;
   logic [vfh_pkg::IDX_W-1:0] run_start_ff, run_start_in;
   logic [vfh_pkg::CNT_W-1:0] run_length_ff, run_length_in;
   logic                      collision_ff, collision_in;
   logic [vfh_pkg::CNT_W-1:0] near_ff, near_in;

   logic [vfh_pkg::IDX_W-1:0] idx;
   logic [vfh_pkg::IDX_W-1:0] sec_start;
   logic [vfh_pkg::CNT_W-1:0] sec_length;
   logic [vfh_pkg::CNT_W:0]   end_full;
   logic [vfh_pkg::IDX_W-1:0] sec_end;
   logic [vfh_pkg::IDX_W:0]   dir_full;
   logic                      stored_long_enough;
   logic                      grown_long_enough;

   assign idx = (beam_index_ff > vfh_pkg::CNT_W'(vfh_pkg::MAX_BEAMS - 1))
              ? vfh_pkg::IDX_W'(vfh_pkg::MAX_BEAMS - 1) : beam_index_ff[vfh_pkg::IDX_W-1:0];

   always_comb begin
      beam_index_in = vfh_pkg::sat_inc(beam_index_ff);
      collision_in  = collision_ff | beam.is_negative;
      near_in       = beam.is_near ? vfh_pkg::sat_inc(near_ff) : near_ff;
      if (beam.is_free) begin
         in_run_in     = 1'b1;
         run_start_in  = in_run_ff ? run_start_ff : idx;
         run_length_in = vfh_pkg::sat_inc(in_run_ff ? run_length_ff : '0);
      end else begin
         in_run_in     = 1'b0;
         run_start_in  = run_start_ff;
         run_length_in = '0;
      end
   end

   // A run closed by a blocked beam reports the stored run; one that reaches the
   // scan end reports the run including this beam.
   assign sec_start  = beam.is_free ? run_start_in  : run_start_ff;
   assign sec_length = beam.is_free ? run_length_in : run_length_ff;
   assign stored_long_enough = vfh_pkg::CMP_W'(run_length_ff) >= vfh_pkg::CMP_W'(min_free_beams);
   assign grown_long_enough  = vfh_pkg::CMP_W'(run_length_in) >= vfh_pkg::CMP_W'(min_free_beams);

   assign end_full = (sec_length == '0) ? (vfh_pkg::CNT_W+1)'(sec_start)
                   : (vfh_pkg::CNT_W+1)'(sec_start) + (vfh_pkg::CNT_W+1)'(sec_length)
                     - (vfh_pkg::CNT_W+1)'(1);
   assign sec_end  = (end_full > (vfh_pkg::CNT_W+1)'(vfh_pkg::MAX_BEAMS - 1))
                   ? vfh_pkg::IDX_W'(vfh_pkg::MAX_BEAMS - 1) : end_full[vfh_pkg::IDX_W-1:0];
   assign dir_full = {1'b0, sec_start} + {1'b0, sec_end};

   always_comb begin
      pair.sector_valid = beam.is_free ? (last_beam && grown_long_enough)
                                       : (in_run_ff && stored_long_enough);
      pair.sector.kind          = vfh_pkg::KIND_SECTOR;
      pair.sector.sector_start  = 10'(sec_start);
      pair.sector.sector_end    = 10'(sec_end);
      pair.sector.sector_width  = 11'(sec_length);
      pair.sector.direction_sum = 11'(dir_full);
      pair.sector.collision     = 1'b0;
      pair.sector.near_count    = '0;
      pair.sector.beam_total    = '0;
      pair.sector.last          = !last_beam;

      pair.summary_valid         = last_beam;
      pair.summary.kind          = vfh_pkg::KIND_SUMMARY;
      pair.summary.sector_start  = '0;
      pair.summary.sector_end    = '0;
      pair.summary.sector_width  = '0;
      pair.summary.direction_sum = '0;
      pair.summary.collision     = collision_in;
      pair.summary.near_count    = 11'(near_in);
      pair.summary.beam_total    = 11'(beam_index_in);
      pair.summary.last          = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && last_beam)) begin
         beam_index_ff <= '0;
         in_run_ff     <= 1'b0;
         run_start_ff  <= '0;
         run_length_ff <= '0;
         collision_ff  <= 1'b0;
         near_ff       <= '0;
      end else if (advance) begin
         beam_index_ff <= beam_index_in;
         in_run_ff     <= in_run_in;
         run_start_ff  <= run_start_in;
         run_length_ff <= run_length_in;
         collision_ff  <= collision_in;
         near_ff       <= near_in;
      end
   end

endmodule

### rtl/vfh_rsp_queue.sv
// Result register pair: holds a sector and a summary result and hands them out in order.
module vfh_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  vfh_pkg::pair_type pair,
   output logic              pair_free,
   vfh_rsp_if.source         rsp
);

   logic                 sec_valid_ff;
   logic                 sum_valid_ff;
   vfh_pkg::result_type  sec_ff;
   vfh_pkg::result_type  sum_ff;
   vfh_pkg::result_type  head;

   // Free when empty, or when the one result still held leaves at this edge.
   assign pair_free = !(sec_valid_ff || sum_valid_ff)
                    || ((sec_valid_ff ^ sum_valid_ff) && rsp.ready);

   assign head = sec_valid_ff ? sec_ff : sum_ff;

   assign rsp.valid         = sec_valid_ff || sum_valid_ff;
   assign rsp.kind          = head.kind;
   assign rsp.sector_start  = head.sector_start;
   assign rsp.sector_end    = head.sector_end;
   assign rsp.sector_width  = head.sector_width;
   assign rsp.direction_sum = head.direction_sum;
   assign rsp.collision     = head.collision;
   assign rsp.near_count    = head.near_count;
   assign rsp.beam_total    = head.beam_total;
   assign rsp.last          = head.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else if (load) begin
         sec_valid_ff <= pair.sector_valid;
         sum_valid_ff <= pair.summary_valid;
      end else if (rsp.valid && rsp.ready) begin
         if (sec_valid_ff) begin
            sec_valid_ff <= 1'b0;
         end else begin
            sum_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sec_ff <= pair.sector;
         sum_ff <= pair.summary;
      end
   end

endmodule

### rtl/vfh_free_sector_finder.sv
// Top level of the free sector finder: input register, configuration registers and wiring.
//
// The block takes the range beams of one laser scan, in order, one item per beam on
// the req_ch channel (distance in millimetres, last_beam on the final beam). It finds
// runs of free beams and reports each run at least min_free_beams long as a sector
// item on rsp_ch; the final beam also yields a summary item with the collision flag,
// the count of near beams and the beam total. The last field marks the final result
// caused by one beam.
// An accepted beam is held in the input register; once the result register pair has room,
// the clamp, the single Q8.8 multiply of the free test and the run bookkeeping load the
// pair, and results are offered on rsp_ch from there. The block takes one beam per cycle
// while the receiver keeps up; a beam that causes both a sector and a summary holds back
// the next beam, since the result register pair hands its two results out one at a time.
// When the receiver stalls, results wait in the result register pair, the input register
// fills, and req_ch.ready falls until room is made. Synchronous reset empties both stages,
// clears the scan state and loads the register defaults. Registers are written through
// csr_we, csr_index and csr_wdata; the user must write them only while no beam is in
// flight, as the block itself does not enforce this.
module vfh_free_sector_finder (
   input  logic                             clock,
   input  logic                             reset,
   vfh_req_if.sink                          req_ch,
   vfh_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [vfh_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vfh_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   vfh_pkg::cfg_type  cfg_ff;
   logic              s1_valid_ff;
   logic [15:0]       s1_distance_ff;
   logic              s1_last_ff;
   logic              advance;
   logic              pair_free;
   vfh_pkg::beam_type beam;
   vfh_pkg::pair_type pair;

   // The held beam moves on when the result pair can take up to two results.
   assign advance      = s1_valid_ff && pair_free;
   assign req_ch.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_distance_ff <= req_ch.distance;
         s1_last_ff     <= req_ch.last_beam;
      end
   end

   // Configuration registers; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vfh_a             <= vfh_pkg::RST_VFH_A;
         cfg_ff.vfh_b_q8          <= vfh_pkg::RST_VFH_B_Q8;
         cfg_ff.body_width        <= vfh_pkg::RST_BODY_WIDTH;
         cfg_ff.min_free_beams    <= vfh_pkg::RST_MIN_FREE_BEAMS;
         cfg_ff.density_threshold <= vfh_pkg::RST_DENSITY_THRESHOLD;
      end else if (csr_we) begin
         case (csr_index)
            vfh_pkg::CSR_VFH_A: begin
               cfg_ff.vfh_a <= csr_wdata;
            end
            vfh_pkg::CSR_VFH_B_Q8: begin
               cfg_ff.vfh_b_q8 <= csr_wdata;
            end
            vfh_pkg::CSR_BODY_WIDTH: begin
               cfg_ff.body_width <= csr_wdata[12:0];
            end
            vfh_pkg::CSR_MIN_FREE_BEAMS: begin
               cfg_ff.min_free_beams <= csr_wdata[10:0];
            end
            vfh_pkg::CSR_DENSITY_THRESHOLD: begin
               cfg_ff.density_threshold <= csr_wdata[12:0];
            end
            default: begin
            end
         endcase
      end
   end

   vfh_beam_eval u_beam_eval (
      .distance (s1_distance_ff),
      .cfg      (cfg_ff),
      .beam     (beam)
   );

   vfh_scan_track u_scan_track (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .beam           (beam),
      .last_beam      (s1_last_ff),
      .min_free_beams (cfg_ff.min_free_beams),
      .pair           (pair)
   );

   vfh_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .pair      (pair),
      .pair_free (pair_free),
      .rsp       (rsp_ch)
   );

endmodule

### rtl/vfh_fsf_checker.sv
// Port-level checks of the free sector finder and their binding to the top level.
module vfh_fsf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [10:0] rsp_sector_width,
   input logic        rsp_collision,
   input logic [10:0] rsp_near_count,
   input logic [10:0] rsp_beam_total,
   input logic        rsp_last
);

   // A result held back by the receiver keeps its content.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_last)
         && $stable(rsp_sector_width) && $stable(rsp_near_count))
      else $error("stalled result changed");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // A summary always closes the results of its beam.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == vfh_pkg::KIND_SUMMARY |-> rsp_last)
      else $error("summary without last");

   // A sector carries at least one beam and no summary fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == vfh_pkg::KIND_SECTOR |->
         rsp_sector_width != 11'd0 && !rsp_collision && rsp_near_count == 11'd0
         && rsp_beam_total == 11'd0)
      else $error("malformed sector");

   // A sector that is not last is followed at once by the summary of the same beam.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_kind == vfh_pkg::KIND_SECTOR && !rsp_last
         |=> rsp_valid && rsp_kind == vfh_pkg::KIND_SUMMARY)
      else $error("summary missing after sector");

endmodule

bind vfh_free_sector_finder vfh_fsf_checker u_fsf_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_kind         (rsp_ch.kind),
   .rsp_sector_width (rsp_ch.sector_width),
   .rsp_collision    (rsp_ch.collision),
   .rsp_near_count   (rsp_ch.near_count),
   .rsp_beam_total   (rsp_ch.beam_total),
   .rsp_last         (rsp_ch.last)
);
